FILE: design/uhte_pkg.sv
// uhte_pkg: shared types, codes and constants of the usb host transfer engine
// used by uhte_ctrl, uhte_dp and usb_host_transfer_engine_top
package uhte_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int PACKET_CAP    = 64;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

    localparam logic [3:0] PID_OUT   = 4'h1;
    localparam logic [3:0] PID_IN    = 4'h9;
    localparam logic [3:0] PID_SETUP = 4'hD;
    localparam logic [3:0] PID_NAK   = 4'hA;
    localparam logic [3:0] PID_STALL = 4'hE;
    localparam logic [6:0] SETUP_LEN = 7'd8;

    typedef enum logic [2:0] {
        CMD_OPEN   = 3'd0,
        CMD_CLOSE  = 3'd1,
        CMD_START  = 3'd2,
        CMD_SETUP  = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_RESULT = 3'd5,
        CMD_RETRY  = 3'd6,
        CMD_DETACH = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_TOKEN  = 3'd1,
        KIND_DONE   = 3'd2,
        KIND_NAK    = 3'd3,
        KIND_REJECT = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_STALL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN2,
        S_EXEC,
        S_OUT
    } state_t;

    // one table entry
    typedef struct packed {
        logic       valid;
        logic [6:0] dev;
        logic [7:0] ep;
        logic [6:0] mps;
        logic       tog;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic              scan_clr;   // clear lookup results, set search keys
        logic              scan_step;  // compare entry at scan index
        logic [SLOT_W-1:0] scan_idx;
        logic              exec;       // perform the command
    } dp_cmd_t;

endpackage

FILE: design/uhte_ctrl.sv
// uhte_ctrl: sequencer for lookup scan, execution and result hand-off
// depends on uhte_pkg
module uhte_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             out_take,
    output logic             out_valid,
    output uhte_pkg::dp_cmd_t dp_cmd
);
    import uhte_pkg::*;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;

    // state and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        dp_cmd.scan_clr  = 1'b0;
        dp_cmd.scan_step = 1'b0;
        dp_cmd.scan_idx  = idx_reg;
        dp_cmd.exec      = 1'b0;
        in_stall         = 1'b1;
        out_valid        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    dp_cmd.scan_clr = 1'b1;
                    idx_next        = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                dp_cmd.scan_step = 1'b1;
                idx_next         = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(TABLE_ENTRIES - 1))
                    state_next = S_SCAN2;
            end
            S_SCAN2:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                dp_cmd.exec = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_exec_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.exec |-> $past(state_reg == S_SCAN2)) else $error("exec without scan");
    a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(dp_cmd.exec)) else $error("result without exec");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accept during result");

endmodule

FILE: design/uhte_dp.sv
// uhte_dp: endpoint table, transfer state and result registers
// depends on uhte_pkg
module uhte_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  uhte_pkg::dp_cmd_t dp_cmd,
    input  logic [2:0]        command,
    input  logic [6:0]        device,
    input  logic [7:0]        ep_addr,
    input  logic [9:0]        max_packet,
    input  logic [15:0]       length,
    input  logic              tog_ok,
    input  logic [3:0]        reply_pid,
    input  logic [6:0]        rx_len,
    output logic [2:0]        kind,
    output logic [3:0]        token_pid,
    output logic [3:0]        endpoint_number,
    output logic              toggle,
    output logic [6:0]        packet_len,
    output logic [1:0]        status,
    output logic [15:0]       byte_count,
    output logic [6:0]        target_dev
);
    import uhte_pkg::*;

    entry_t tbl_reg [TABLE_ENTRIES];

    // latched command beat
    logic [2:0]  cmd_reg;
    logic [6:0]  dev_reg;
    logic [7:0]  ep_reg;
    logic [6:0]  mps_reg;
    logic [15:0] len_reg;
    logic        tok_reg;
    logic [3:0]  rpid_reg;
    logic [6:0]  rx_reg;

    // scan results: hit for key ep, hit for ep 0x80 of dev, first two free slots
    logic              hit_a_reg, hit_b_reg, fr1_reg, fr2_reg;
    logic [SLOT_W-1:0] sa_reg, sb_reg, f1_reg, f2_reg;

    logic              busy_reg, nak_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [3:0]        tokn_reg;
    logic [15:0]       rem_reg, moved_reg;
    logic [6:0]        last_reg;

    logic [2:0]  kind_reg;
    logic [3:0]  opid_reg, onum_reg;
    logic        otog_reg;
    logic [6:0]  oplen_reg, odev_reg;
    logic [1:0]  ost_reg;
    logic [15:0] ocnt_reg;

    logic [7:0] key_a;
    entry_t     se;
    logic       match_a, match_b;

    // lookup key: setup and ep0 open search 0x00
    always_comb
    begin
        key_a = ep_reg;
        if (cmd_reg == CMD_SETUP || (cmd_reg == CMD_OPEN && ep_reg[3:0] == 4'd0))
            key_a = 8'h00;
        se      = tbl_reg[dp_cmd.scan_idx];
        match_a = se.valid && se.dev == dev_reg && se.ep == key_a;
        match_b = se.valid && se.dev == dev_reg && se.ep == 8'h80;
    end

    // command beat capture and scan
    always_ff @(posedge clk)
    begin
        if (dp_cmd.scan_clr)
        begin
            cmd_reg   <= command;
            dev_reg   <= device;
            ep_reg    <= ep_addr;
            mps_reg   <= (max_packet > 10'(PACKET_CAP)) ? 7'(PACKET_CAP) : max_packet[6:0];
            len_reg   <= length;
            tok_reg   <= tog_ok;
            rpid_reg  <= reply_pid;
            rx_reg    <= (rx_len > 7'(PACKET_CAP)) ? 7'(PACKET_CAP) : rx_len;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
            fr1_reg   <= 1'b0;
            fr2_reg   <= 1'b0;
            sa_reg    <= '0;
            sb_reg    <= '0;
            f1_reg    <= '0;
            f2_reg    <= '0;
        end
        else if (dp_cmd.scan_step)
        begin
            if (match_a && !hit_a_reg)
            begin
                hit_a_reg <= 1'b1;
                sa_reg    <= dp_cmd.scan_idx;
            end
            if (match_b && !hit_b_reg)
            begin
                hit_b_reg <= 1'b1;
                sb_reg    <= dp_cmd.scan_idx;
            end
            if (!se.valid)
            begin
                if (!fr1_reg)
                begin
                    fr1_reg <= 1'b1;
                    f1_reg  <= dp_cmd.scan_idx;
                end
                else if (!fr2_reg)
                begin
                    fr2_reg <= 1'b1;
                    f2_reg  <= dp_cmd.scan_idx;
                end
            end
        end
    end

    // execution
    entry_t tn [TABLE_ENTRIES];
    entry_t ce;
    logic              busy_n, nak_n;
    logic [SLOT_W-1:0] slot_n;
    logic [3:0]        tokn_n;
    logic [15:0]       rem_n, moved_n;
    logic [6:0]        last_n, plen;
    logic [2:0]        k_n;
    logic [3:0]        pid_n, num_n;
    logic              tg_n;
    logic [6:0]        pl_n, dv_n;
    logic [1:0]        st_n;
    logic [15:0]       cnt_n;
    logic [16:0]       sum;
    logic              do_issue, do_finish;
    logic [1:0]        fin_st;
    logic [15:0]       fin_cnt;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            tn[i] = tbl_reg[i];
        busy_n    = busy_reg;
        nak_n     = nak_reg;
        slot_n    = slot_reg;
        tokn_n    = tokn_reg;
        rem_n     = rem_reg;
        moved_n   = moved_reg;
        last_n    = last_reg;
        k_n       = KIND_NONE;
        pid_n     = '0;
        num_n     = '0;
        tg_n      = 1'b0;
        pl_n      = '0;
        dv_n      = '0;
        st_n      = '0;
        cnt_n     = '0;
        do_issue  = 1'b0;
        do_finish = 1'b0;
        fin_st    = ST_OK;
        fin_cnt   = '0;
        sum       = '0;
        plen      = '0;
        ce        = tbl_reg[slot_reg];
        case (cmd_reg)
            CMD_OPEN:
            begin
                if (ep_reg[3:0] == 4'd0)
                begin
                    if (!hit_a_reg && !hit_b_reg)
                    begin
                        if (fr1_reg)
                            tn[f1_reg] = '{1'b1, dev_reg, 8'h00, mps_reg, 1'b0};
                        if (fr2_reg)
                            tn[f2_reg] = '{1'b1, dev_reg, 8'h80, mps_reg, 1'b0};
                        if (!fr2_reg)
                            k_n = KIND_REJECT;
                    end
                    else if (!hit_a_reg || !hit_b_reg)
                    begin
                        if (fr1_reg)
                            tn[f1_reg] = '{1'b1, dev_reg, hit_a_reg ? 8'h80 : 8'h00,
                                           mps_reg, 1'b0};
                        else
                            k_n = KIND_REJECT;
                    end
                end
                else if (!hit_a_reg)
                begin
                    if (fr1_reg)
                        tn[f1_reg] = '{1'b1, dev_reg, ep_reg, mps_reg, 1'b0};
                    else
                        k_n = KIND_REJECT;
                end
            end
            CMD_CLOSE:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_reg[i].dev == dev_reg)
                        tn[i].valid = 1'b0;
            end
            CMD_START:
            begin
                if (busy_reg || !hit_a_reg)
                    k_n = KIND_REJECT;
                else
                begin
                    nak_n   = 1'b0;
                    slot_n  = sa_reg;
                    ce      = tbl_reg[sa_reg];
                    rem_n   = len_reg;
                    moved_n = '0;
                    if (ep_reg[7])
                    begin
                        tokn_n = PID_IN;
                        last_n = '0;
                    end
                    else
                    begin
                        tokn_n = PID_OUT;
                        last_n = (len_reg < 16'(ce.mps)) ? len_reg[6:0] : ce.mps;
                    end
                    do_issue = 1'b1;
                end
            end
            CMD_SETUP:
            begin
                if (busy_reg || !hit_a_reg || !hit_b_reg)
                    k_n = KIND_REJECT;
                else
                begin
                    nak_n          = 1'b0;
                    tn[sa_reg].tog = 1'b0;
                    tn[sb_reg].tog = 1'b1;
                    slot_n         = sa_reg;
                    ce             = tn[sa_reg];
                    tokn_n         = PID_SETUP;
                    rem_n          = 16'(SETUP_LEN);
                    moved_n        = '0;
                    last_n         = SETUP_LEN;
                    do_issue       = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                if (hit_a_reg)
                    tn[sa_reg].tog = 1'b0;
            end
            CMD_RESULT:
            begin
                if (busy_reg)
                begin
                    if (!ce.valid)
                        busy_n = 1'b0;
                    else if (tok_reg)
                    begin
                        tn[slot_reg].tog = ~ce.tog;
                        ce.tog           = ~ce.tog;
                        if (tokn_reg == PID_SETUP || tokn_reg == PID_OUT)
                        begin
                            rem_n   = (rem_reg >= 16'(last_reg)) ?
                                      rem_reg - 16'(last_reg) : 16'd0;
                            moved_n = moved_reg + 16'(last_reg);
                            if (rem_n == 16'd0)
                            begin
                                do_finish = 1'b1;
                                fin_cnt   = moved_n;
                            end
                            else
                            begin
                                tokn_n   = PID_OUT;
                                last_n   = (rem_n < 16'(ce.mps)) ? rem_n[6:0] : ce.mps;
                                do_issue = 1'b1;
                            end
                        end
                        else if (tokn_reg == PID_IN)
                        begin
                            sum     = 17'(moved_reg) + 17'(rx_reg);
                            moved_n = sum[16] ? 16'hFFFF : sum[15:0];
                            if (rx_reg < ce.mps || moved_n == rem_reg)
                            begin
                                do_finish = 1'b1;
                                fin_cnt   = moved_n;
                            end
                            else
                                do_issue = 1'b1;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                            fin_st    = ST_FAIL;
                        end
                    end
                    else if (rpid_reg == PID_STALL)
                    begin
                        tn[slot_reg].tog = 1'b0;
                        do_finish        = 1'b1;
                        fin_st           = ST_STALL;
                    end
                    else if (rpid_reg == PID_NAK)
                    begin
                        busy_n = 1'b0;
                        nak_n  = 1'b1;
                        k_n    = KIND_NAK;
                        pid_n  = tokn_reg;
                        num_n  = ce.ep[3:0];
                        dv_n   = ce.dev;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                        fin_st    = ST_FAIL;
                    end
                end
            end
            CMD_RETRY:
            begin
                if (nak_reg)
                begin
                    nak_n = 1'b0;
                    if (ce.valid)
                        do_issue = 1'b1;
                end
            end
            default:
            begin
                busy_n = 1'b0;
                nak_n  = 1'b0;
            end
        endcase
        // token issue and transfer end
        if (do_issue)
        begin
            busy_n = 1'b1;
            k_n    = KIND_TOKEN;
            pid_n  = tokn_n;
            num_n  = ce.ep[3:0];
            tg_n   = (tokn_n == PID_SETUP) ? 1'b0 : ce.tog;
            plen   = (tokn_n == PID_IN) ? 7'd0 : last_n;
            pl_n   = plen;
            dv_n   = ce.dev;
        end
        if (do_finish)
        begin
            busy_n = 1'b0;
            k_n    = KIND_DONE;
            pid_n  = tokn_n;
            num_n  = ce.ep[3:0];
            st_n   = fin_st;
            cnt_n  = fin_cnt;
            dv_n   = ce.dev;
        end
    end

    // table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tbl_reg[i] <= '0;
            busy_reg  <= 1'b0;
            nak_reg   <= 1'b0;
            slot_reg  <= '0;
            tokn_reg  <= '0;
            rem_reg   <= '0;
            moved_reg <= '0;
            last_reg  <= '0;
        end
        else if (dp_cmd.exec)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tbl_reg[i] <= tn[i];
            busy_reg  <= busy_n;
            nak_reg   <= nak_n;
            slot_reg  <= slot_n;
            tokn_reg  <= tokn_n;
            rem_reg   <= rem_n;
            moved_reg <= moved_n;
            last_reg  <= last_n;
        end
    end

    // result beat registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            kind_reg  <= k_n;
            opid_reg  <= pid_n;
            onum_reg  <= num_n;
            otog_reg  <= tg_n;
            oplen_reg <= pl_n;
            ost_reg   <= st_n;
            ocnt_reg  <= cnt_n;
            odev_reg  <= dv_n;
        end
    end

    assign kind            = kind_reg;
    assign token_pid       = opid_reg;
    assign endpoint_number = onum_reg;
    assign toggle          = otog_reg;
    assign packet_len      = oplen_reg;
    assign status          = ost_reg;
    assign byte_count      = ocnt_reg;
    assign target_dev      = odev_reg;

    a_busy_nak: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && nak_reg)) else $error("busy and nak wait together");
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.exec && k_n == KIND_TOKEN |=> busy_reg) else $error("token without busy");
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg <= 7'(PACKET_CAP)) else $error("packet over cap");

endmodule

FILE: design/usb_host_transfer_engine_top.sv
// usb_host_transfer_engine_top: usb host transfer engine top level
// depends on uhte_pkg, uhte_ctrl, uhte_dp
//
//   channel   direction  handshake          payload
//   command   in         in_valid/in_stall  command .. rx_len
//   result    out        out_valid/out_stall kind .. target_dev
//
// a command beat is accepted, then the sequencer walks all 16 entries of
// the endpoint table, passes a settle and an execute state, and the result
// beat is held until taken; a stalled result holds the next command off
// reset clears the endpoint table valid bits and all transfer state
module usb_host_transfer_engine_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [6:0]  device,
    input  logic [7:0]  ep_addr,
    input  logic [9:0]  max_packet,
    input  logic [15:0] length,
    input  logic        tog_ok,
    input  logic [3:0]  reply_pid,
    input  logic [6:0]  rx_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  token_pid,
    output logic [3:0]  endpoint_number,
    output logic        toggle,
    output logic [6:0]  packet_len,
    output logic [1:0]  status,
    output logic [15:0] byte_count,
    output logic [6:0]  target_dev
);
    import uhte_pkg::*;

    dp_cmd_t dp_cmd;

    // sequencer
    uhte_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_take  (!out_stall),
        .out_valid (out_valid),
        .dp_cmd    (dp_cmd)
    );

    // table and transfer datapath
    uhte_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .command         (command),
        .device          (device),
        .ep_addr         (ep_addr),
        .max_packet      (max_packet),
        .length          (length),
        .tog_ok          (tog_ok),
        .reply_pid       (reply_pid),
        .rx_len          (rx_len),
        .kind            (kind),
        .token_pid       (token_pid),
        .endpoint_number (endpoint_number),
        .toggle          (toggle),
        .packet_len      (packet_len),
        .status          (status),
        .byte_count      (byte_count),
        .target_dev      (target_dev)
    );

endmodule
